### rtl/fps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types, widths and the microprogram of the dead-time plant stepper.
// ----------------------------------------------------------------------------
package fps_pkg;

	localparam int DATA_W  = 32;
	localparam int MUL_W   = 34;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int ACC_W   = 50;
	localparam int STEP_W  = 4;
	localparam int INDEX_W = 3;

	localparam logic signed [ACC_W-1:0] Y_MAX = 50'sd2147483647;
	localparam logic signed [ACC_W-1:0] Y_MIN = -50'sd2147483648;

	// request opcodes
	localparam logic OP_STEP    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// configuration register indexes
	localparam logic [INDEX_W-1:0] REG_DECAY    = 3'd0;
	localparam logic [INDEX_W-1:0] REG_GAIN     = 3'd1;
	localparam logic [INDEX_W-1:0] REG_DSTEPS   = 3'd2;
	localparam logic [INDEX_W-1:0] REG_DFRAC    = 3'd3;
	localparam logic [INDEX_W-1:0] REG_FRICTION = 3'd4;
	localparam logic [INDEX_W-1:0] REG_INIT     = 3'd5;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_DECAY,
		MUL_INTERP,
		MUL_GAIN
	} mul_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_TAP0,
		RD_TAP1
	} rd_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_RESTART,
		JMP_OUT_BUSY
	} jmp_t;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_STEP,
		FIN_RESTART
	} fin_t;

	typedef struct packed {
		jmp_t     cond;
		step_t    target;
		logic     mem_write;
		mul_sel_t mul_sel;
		rd_sel_t  rd_sel;
		acc_op_t  acc_op;
		logic     u0_load;
		logic     ud_load;
		fin_t     fin;
	} ctrl_t;

	localparam step_t STEP_FINISH  = 4'd8;
	localparam step_t STEP_RESTART = 4'd9;

	localparam ctrl_t CTRL_NOP = '{
		cond: JMP_NONE, target: '0, mem_write: 1'b0, mul_sel: MUL_NONE,
		rd_sel: RD_NONE, acc_op: ACC_NONE, u0_load: 1'b0, ud_load: 1'b0,
		fin: FIN_NONE
	};

	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = CTRL_NOP;
		case (step)
			4'd0: begin
				w.cond   = JMP_RESTART;
				w.target = STEP_RESTART;
			end
			4'd1: begin
				w.mem_write = 1'b1;
				w.mul_sel   = MUL_DECAY;
			end
			4'd2: begin
				w.rd_sel = RD_TAP0;
				w.acc_op = ACC_LOAD;
			end
			4'd3: begin
				w.u0_load = 1'b1;
				w.rd_sel  = RD_TAP1;
			end
			4'd4: begin
				w.mul_sel = MUL_INTERP;
			end
			4'd5: begin
				w.ud_load = 1'b1;
			end
			4'd6: begin
				w.mul_sel = MUL_GAIN;
			end
			4'd7: begin
				w.acc_op = ACC_ADD;
			end
			STEP_FINISH: begin
				w.cond   = JMP_OUT_BUSY;
				w.target = STEP_FINISH;
				w.fin    = FIN_STEP;
			end
			STEP_RESTART: begin
				w.cond   = JMP_OUT_BUSY;
				w.target = STEP_RESTART;
				w.fin    = FIN_RESTART;
			end
			default: begin
				w = CTRL_NOP;
			end
		endcase
		return w;
	endfunction

endpackage

### rtl/fps_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fps_mul (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [fps_pkg::MUL_W-1:0]      a,
	input  logic signed [fps_pkg::MUL_W-1:0]      b,
	output logic signed [fps_pkg::PROD_W-1:0]     prod
);

	logic signed [fps_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= fps_pkg::PROD_W'(a) * fps_pkg::PROD_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

### rtl/fopdt_plant_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fopdt_plant_step_core
// First-order plant with fractional dead time, run by a small microprogram.
// ----------------------------------------------------------------------------
// Requests come in on in_valid/in_ready with opcode and drive_sample; each
// request yields one plant_output on out_valid/out_ready.
// A step request runs words 0 to 8 of the ten-word program over one shared
// 34x34 multiplier and a one-port delay-line memory; a new request is taken
// only once the previous one has finished. The multiplier (three products
// per step) and the two memory reads set the length of the program. A
// restart request jumps from the first word straight to the restart word.
// in_ready is high whenever no request is in progress, so the next request
// is taken while the previous result still waits in the output register.
// If the receiver stalls, the sequencer holds on its last word until the
// output register frees up.
// Configuration writes (wr_en, wr_index, wr_data) are taken at once and are
// expected only while the block is idle.
// Reset clears the configuration, the control state, the write pointer and
// out_valid; the delay line is tracked by a fill count, so unwritten entries
// read as zero and no clearing pass is needed. Restart resets the same count.
// ----------------------------------------------------------------------------
module fopdt_plant_step_core #(
	parameter int BUF_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic signed [31:0] drive_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] plant_output
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int FW = $clog2(BUF_DEPTH + 1);

	function automatic logic [63:0][AW-1:0] build_dmod();
		logic [63:0][AW-1:0] t;
		for (int i = 0; i < 64; i++) begin
			t[i] = AW'(i % BUF_DEPTH);
		end
		return t;
	endfunction

	localparam logic [63:0][AW-1:0] DMOD = build_dmod();

	// configuration
	logic [29:0]        decay_q;
	logic signed [31:0] gain_q;
	logic [5:0]         dsteps_q;
	logic [15:0]        dfrac_q;
	logic [30:0]        fric_q;
	logic signed [31:0] init_q;

	// sequencer and plant state
	logic                   busy_q;
	fps_pkg::step_t         step_q;
	logic [AW-1:0]          ptr_q;
	logic [FW-1:0]          fill_q;
	logic signed [31:0]     y_q;
	logic                   out_valid_q;
	logic signed [31:0]     out_q;

	// request payload and datapath
	logic                   op_q;
	logic signed [31:0]     u_in_q;
	logic [AW-1:0]          i0_q;
	logic [AW-1:0]          i1_q;
	logic                   v0_q;
	logic                   v1_q;
	logic [FW-1:0]          fill_nx_q;
	logic signed [31:0]     rd_q;
	logic                   rv_q;
	logic signed [31:0]     u0_q;
	logic signed [31:0]     ud_q;
	logic signed [fps_pkg::ACC_W-1:0] acc_q;

	logic signed [31:0] mem [BUF_DEPTH];

	fps_pkg::ctrl_t cw;
	logic           taken;
	logic           act;
	logic           accept;

	logic [AW-1:0]  d_mod;
	logic [AW:0]    diff;
	logic [AW-1:0]  i0_c;
	logic [AW-1:0]  i1_c;
	logic [FW-1:0]  fill_nx_c;

	logic signed [31:0]                rd_val;
	logic signed [fps_pkg::MUL_W-1:0]  mul_a;
	logic signed [fps_pkg::MUL_W-1:0]  mul_b;
	logic signed [fps_pkg::PROD_W-1:0] prod;
	logic signed [fps_pkg::MUL_W-1:0]  ud_wide;
	logic signed [fps_pkg::ACC_W-1:0]  fr_s;
	logic signed [fps_pkg::ACC_W-1:0]  y_fr;
	logic signed [31:0]                y_sat;

	assign accept   = in_valid & ~busy_q;
	assign in_ready = ~busy_q;

	assign cw = fps_pkg::ucode(step_q);

	always_comb begin
		case (cw.cond)
			fps_pkg::JMP_RESTART:  taken = (op_q == fps_pkg::OP_RESTART);
			fps_pkg::JMP_OUT_BUSY: taken = out_valid_q & ~out_ready;
			default:               taken = 1'b0;
		endcase
	end

	assign act = busy_q & ~taken;

	// tap addresses and fill check, worked out when the request is taken
	always_comb begin
		d_mod = DMOD[dsteps_q];
		diff  = {1'b0, ptr_q} - {1'b0, d_mod};
		if (diff[AW]) begin
			i0_c = AW'(diff + (AW + 1)'(BUF_DEPTH));
		end else begin
			i0_c = diff[AW-1:0];
		end
		if (i0_c == '0) begin
			i1_c = AW'(BUF_DEPTH - 1);
		end else begin
			i1_c = i0_c - AW'(1);
		end
		if (fill_q == FW'(BUF_DEPTH)) begin
			fill_nx_c = fill_q;
		end else begin
			fill_nx_c = fill_q + FW'(1);
		end
	end

	assign rd_val = rv_q ? rd_q : 32'sd0;

	always_comb begin
		case (cw.mul_sel)
			fps_pkg::MUL_DECAY: begin
				mul_a = $signed(fps_pkg::MUL_W'(decay_q));
				mul_b = fps_pkg::MUL_W'(y_q);
			end
			fps_pkg::MUL_INTERP: begin
				mul_a = $signed(fps_pkg::MUL_W'(dfrac_q));
				mul_b = fps_pkg::MUL_W'(rd_val) - fps_pkg::MUL_W'(u0_q);
			end
			fps_pkg::MUL_GAIN: begin
				mul_a = fps_pkg::MUL_W'(gain_q);
				mul_b = fps_pkg::MUL_W'(ud_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	fps_mul u_mul (
		.clk  (clk),
		.en   (act && (cw.mul_sel != fps_pkg::MUL_NONE)),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign ud_wide = fps_pkg::MUL_W'(u0_q) + $signed(prod[49:16]);

	// friction toward zero, then saturation
	always_comb begin
		fr_s = $signed(fps_pkg::ACC_W'(fric_q));
		y_fr = acc_q;
		if (fric_q != '0) begin
			if (!y_q[31] && (y_q != 32'sd0)) begin
				y_fr = acc_q - fr_s;
				if (y_fr < 0) begin
					y_fr = '0;
				end
			end else if (y_q[31]) begin
				y_fr = acc_q + fr_s;
				if (y_fr > 0) begin
					y_fr = '0;
				end
			end
		end
		if (y_fr > fps_pkg::Y_MAX) begin
			y_sat = 32'sh7fffffff;
		end else if (y_fr < fps_pkg::Y_MIN) begin
			y_sat = 32'sh80000000;
		end else begin
			y_sat = y_fr[31:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q     <= '0;
			gain_q      <= '0;
			dsteps_q    <= '0;
			dfrac_q     <= '0;
			fric_q      <= '0;
			init_q      <= '0;
			busy_q      <= 1'b0;
			step_q      <= '0;
			ptr_q       <= '0;
			fill_q      <= '0;
			y_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					fps_pkg::REG_DECAY:    decay_q  <= wr_data[29:0];
					fps_pkg::REG_GAIN:     gain_q   <= wr_data;
					fps_pkg::REG_DSTEPS:   dsteps_q <= wr_data[5:0];
					fps_pkg::REG_DFRAC:    dfrac_q  <= wr_data[15:0];
					fps_pkg::REG_FRICTION: fric_q   <= wr_data[30:0];
					fps_pkg::REG_INIT:     init_q   <= wr_data;
					default: ;
				endcase
			end

			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (taken) begin
					step_q <= cw.target;
				end else if (cw.fin != fps_pkg::FIN_NONE) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else begin
					step_q <= step_q + fps_pkg::STEP_W'(1);
				end
			end

			if (act && cw.mem_write) begin
				fill_q <= fill_nx_q;
				if (ptr_q == AW'(BUF_DEPTH - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + AW'(1);
				end
			end

			if (act && (cw.fin == fps_pkg::FIN_STEP)) begin
				y_q         <= y_sat;
				out_valid_q <= 1'b1;
			end else if (act && (cw.fin == fps_pkg::FIN_RESTART)) begin
				y_q         <= init_q;
				ptr_q       <= '0;
				fill_q      <= '0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode;
			u_in_q    <= drive_sample;
			i0_q      <= i0_c;
			i1_q      <= i1_c;
			v0_q      <= FW'(i0_c) < fill_nx_c;
			v1_q      <= FW'(i1_c) < fill_nx_c;
			fill_nx_q <= fill_nx_c;
		end
		if (act) begin
			case (cw.acc_op)
				fps_pkg::ACC_LOAD: acc_q <= fps_pkg::ACC_W'($signed(prod[67:30]));
				fps_pkg::ACC_ADD:  acc_q <= acc_q + $signed(prod[65:16]);
				default: ;
			endcase
			if (cw.u0_load) begin
				u0_q <= rd_val;
			end
			if (cw.ud_load) begin
				ud_q <= ud_wide[31:0];
			end
			if (cw.fin == fps_pkg::FIN_STEP) begin
				out_q <= y_sat;
			end else if (cw.fin == fps_pkg::FIN_RESTART) begin
				out_q <= init_q;
			end
		end
	end

	// delay line
	always_ff @(posedge clk) begin
		if (act && cw.mem_write) begin
			mem[ptr_q] <= u_in_q;
		end
		if (act && (cw.rd_sel == fps_pkg::RD_TAP0)) begin
			rd_q <= mem[i0_q];
			rv_q <= v0_q;
		end else if (act && (cw.rd_sel == fps_pkg::RD_TAP1)) begin
			rd_q <= mem[i1_q];
			rv_q <= v1_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign plant_output = out_q;

endmodule
